@@ hdl/ipfr_pkg.sv @@
// Shared types and constants for the IPv4 fragment reassembly slot table.
package ipfr_pkg;

    localparam int SLOTS  = 10;
    localparam int SLOT_W = 6;

    localparam logic [15:0] AGE_RESET = 16'd50;
    localparam logic [15:0] HDR_BYTES = 16'd20;
    localparam int          MF_POS    = 13;
    localparam int          OFS_W     = 13;
    localparam int          OFS_SHIFT = 3;

    localparam logic [1:0] REQ_FRAG  = 2'd0;
    localparam logic [1:0] REQ_INVAL = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [3:0] ST_HELD       = 4'd0;
    localparam logic [3:0] ST_COMPLETE   = 4'd1;
    localparam logic [3:0] ST_NO_SOCKET  = 4'd2;
    localparam logic [3:0] ST_POOL_FIRST = 4'd3;
    localparam logic [3:0] ST_NO_SLOT    = 4'd4;
    localparam logic [3:0] ST_POOL_DROP  = 4'd5;
    localparam logic [3:0] ST_ORDER_DROP = 4'd6;
    localparam logic [3:0] ST_NO_MATCH   = 4'd7;
    localparam logic [3:0] ST_INVAL_DONE = 4'd8;
    localparam logic [3:0] ST_CLEARED    = 4'd9;

    // What the cells do with the transaction in flight.
    typedef enum logic [2:0] {
        M_NONE,
        M_INVAL,
        M_CLEAR,
        M_FIRST,
        M_LATER
    } mode_t;

    // Request fields broadcast to every cell while a transaction is in the chain.
    typedef struct packed {
        mode_t       mode;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] ident;
        logic [7:0]  proto;
        logic [15:0] offset;
        logic        more;
        logic [15:0] plen;
        logic [7:0]  sock;
        logic        pool;
        logic [31:0] tick;
        logic [15:0] age_limit;
    } req_t;

    // Token handed from cell to cell; carries the result being built.
    typedef struct packed {
        logic        active;
        logic        done;
        logic [3:0]  status;
        logic [SLOT_W-1:0] slot;
        logic [15:0] total_len;
        logic [7:0]  socket;
        logic [6:0]  freed;
    } token_t;

endpackage

@@ hdl/ip_fragment_reassembly_table.sv @@
// Top level of the IPv4 fragment reassembly slot table.
//
// Usage:
//   Input channel (in_valid / in_stall): one request per transaction, either a
//   fragment, an invalidate of one socket, or a clear of all slots. A
//   transaction is taken on a clock edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall): exactly one result per request.
//   Config channel (cfg_valid / cfg_ready): writes stale_age_limit; ready is
//   always high. Write it only while the table is idle.
// Flow:
//   The request walks a row of SLOTS cells, one cell per cycle, and one
//   request is in the row at a time: the input reopens only when the
//   result leaves the end of the row, so a new request cannot enter before
//   the last one is through.
// Stalls:
//   A two-entry result buffer lets the next request enter while a finished
//   result waits on out_stall; a second waiting result stalls the input.
// Reset:
//   All slots go free, the tick counter goes to zero and stale_age_limit
//   returns to 50. No clearing pass is needed; the table is usable at once.
module ip_fragment_reassembly_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] ident,
    input  logic [7:0]  proto,
    input  logic [15:0] frag_field,
    input  logic [15:0] payload_len,
    input  logic        socket_valid,
    input  logic [7:0]  socket_id,
    input  logic        pool_ok,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  status,
    output logic [5:0]  slot,
    output logic [15:0] total_len,
    output logic [7:0]  done_socket,
    output logic [6:0]  freed_count
);
    import ipfr_pkg::*;

    logic [15:0] age_limit_reg;
    logic [31:0] tick_reg, tick_next;
    req_t        req_reg, req_next;
    token_t      tok0_reg, tok0_next;
    logic        busy_reg;
    token_t      out_reg;
    logic        out_valid_reg;
    token_t      hold_reg;
    logic        hold_valid_reg;

    token_t      chain [0:SLOTS];

    logic        in_fire;
    logic        out_fire;
    logic        end_active;
    logic [15:0] offset_bytes;

    assign cfg_ready  = 1'b1;
    assign in_stall   = busy_reg || hold_valid_reg;
    assign in_fire    = in_valid && !in_stall;
    assign out_fire   = out_valid_reg && !out_stall;
    assign end_active = chain[SLOTS].active;

    // Offset in 8-byte units to bytes.
    assign offset_bytes = {frag_field[OFS_W-1:0], {OFS_SHIFT{1'b0}}};

    // Decode the request and seed the token. Early outcomes are marked done
    // so the cells pass the token untouched.
    always_comb
    begin
        tick_next          = tick_reg;
        req_next           = req_reg;
        tok0_next          = '0;
        if (in_fire)
        begin
            req_next.src       = src_addr;
            req_next.dst       = dst_addr;
            req_next.ident     = ident;
            req_next.proto     = proto;
            req_next.offset    = offset_bytes;
            req_next.more      = frag_field[MF_POS];
            req_next.plen      = payload_len;
            req_next.sock      = socket_id;
            req_next.pool      = pool_ok;
            req_next.age_limit = age_limit_reg;
            tok0_next.active   = 1'b1;
            case (req_type)
                REQ_INVAL:
                begin
                    req_next.mode    = M_INVAL;
                    tok0_next.status = ST_INVAL_DONE;
                end
                REQ_CLEAR:
                begin
                    req_next.mode    = M_CLEAR;
                    tok0_next.status = ST_CLEARED;
                end
                REQ_FRAG:
                begin
                    tick_next = tick_reg + 32'd1;
                    if (offset_bytes != 16'd0)
                    begin
                        req_next.mode    = M_LATER;
                        tok0_next.status = ST_NO_MATCH;
                    end
                    else if (!socket_valid)
                    begin
                        req_next.mode    = M_NONE;
                        tok0_next.status = ST_NO_SOCKET;
                        tok0_next.done   = 1'b1;
                    end
                    else if (!pool_ok)
                    begin
                        req_next.mode    = M_NONE;
                        tok0_next.status = ST_POOL_FIRST;
                        tok0_next.done   = 1'b1;
                    end
                    else
                    begin
                        req_next.mode    = M_FIRST;
                        tok0_next.status = ST_NO_SLOT;
                    end
                end
                default:
                begin
                    req_next.mode    = M_NONE;
                    tok0_next.status = ST_NO_MATCH;
                    tok0_next.done   = 1'b1;
                end
            endcase
        end
        req_next.tick = tick_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg  <= AGE_RESET;
            tick_reg       <= 32'd0;
            tok0_reg       <= '0;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                age_limit_reg <= cfg_data;
            tick_reg <= tick_next;
            tok0_reg <= tok0_next;
            if (in_fire)
                busy_reg <= 1'b1;
            else if (end_active)
                busy_reg <= 1'b0;

            // Two-entry result buffer.
            if (hold_valid_reg)
            begin
                if (out_fire)
                    hold_valid_reg <= 1'b0;
            end
            else if (end_active)
            begin
                if (!out_valid_reg || out_fire)
                    out_valid_reg <= 1'b1;
                else
                    hold_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; no reset needed.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        if (hold_valid_reg)
        begin
            if (out_fire)
                out_reg <= hold_reg;
        end
        else if (end_active)
        begin
            if (!out_valid_reg || out_fire)
                out_reg <= chain[SLOTS];
            else
                hold_reg <= chain[SLOTS];
        end
    end

    // Row of slot cells; the token advances one cell per cycle.
    assign chain[0] = tok0_reg;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        ipfr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .slot_idx (SLOT_W'(g)),
            .req      (req_reg),
            .tok_in   (chain[g]),
            .tok_out  (chain[g+1])
        );
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign slot        = out_reg.slot;
    assign total_len   = out_reg.total_len;
    assign done_socket = out_reg.socket;
    assign freed_count = out_reg.freed;

endmodule

@@ hdl/ipfr_cell.sv @@
// One reassembly slot: holds the slot state and acts on the passing token.
module ipfr_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ipfr_pkg::SLOT_W-1:0]   slot_idx,
    input  ipfr_pkg::req_t                req,
    input  ipfr_pkg::token_t              tok_in,
    output ipfr_pkg::token_t              tok_out
);
    import ipfr_pkg::*;

    logic        busy_reg, busy_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic [15:0] ident_reg, ident_next;
    logic [7:0]  proto_reg, proto_next;
    logic [7:0]  socket_reg, socket_next;
    logic [16:0] bytes_reg, bytes_next;
    logic [31:0] last_reg, last_next;
    token_t      tok_reg, tok_next;

    logic [31:0] age;
    logic        stale;
    logic        key_hit;
    logic [16:0] bytes_sum;

    assign age       = req.tick - last_reg;
    assign stale     = busy_reg && (age > {16'd0, req.age_limit});
    assign key_hit   = busy_reg && (src_reg == req.src) && (dst_reg == req.dst) &&
                       (ident_reg == req.ident) && (proto_reg == req.proto);
    assign bytes_sum = bytes_reg + {1'b0, req.plen};

    always_comb
    begin
        busy_next   = busy_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        ident_next  = ident_reg;
        proto_next  = proto_reg;
        socket_next = socket_reg;
        bytes_next  = bytes_reg;
        last_next   = last_reg;
        tok_next    = tok_in;
        if (tok_in.active)
        begin
            case (req.mode)
                M_INVAL:
                begin
                    if (busy_reg && (socket_reg == req.sock))
                    begin
                        busy_next      = 1'b0;
                        tok_next.freed = tok_in.freed + 7'd1;
                    end
                end
                M_CLEAR:
                begin
                    if (busy_reg)
                    begin
                        busy_next      = 1'b0;
                        tok_next.freed = tok_in.freed + 7'd1;
                    end
                end
                M_FIRST:
                begin
                    if (!tok_in.done)
                    begin
                        if (stale)
                            tok_next.freed = tok_in.freed + 7'd1;
                        // free now (or reclaimed above): claim it
                        if (!busy_reg || stale)
                        begin
                            busy_next       = 1'b1;
                            src_next        = req.src;
                            dst_next        = req.dst;
                            ident_next      = req.ident;
                            proto_next      = req.proto;
                            socket_next     = req.sock;
                            bytes_next      = {1'b0, req.plen};
                            last_next       = req.tick;
                            tok_next.done   = 1'b1;
                            tok_next.status = ST_HELD;
                            tok_next.slot   = slot_idx;
                        end
                    end
                end
                M_LATER:
                begin
                    if (!tok_in.done && key_hit)
                    begin
                        tok_next.done = 1'b1;
                        tok_next.slot = slot_idx;
                        if (!req.pool)
                        begin
                            busy_next       = 1'b0;
                            tok_next.status = ST_POOL_DROP;
                        end
                        else if ({1'b0, req.offset} != bytes_reg)
                        begin
                            busy_next       = 1'b0;
                            tok_next.status = ST_ORDER_DROP;
                        end
                        else
                        begin
                            last_next  = req.tick;
                            bytes_next = bytes_sum;
                            if (!req.more)
                            begin
                                busy_next          = 1'b0;
                                tok_next.status    = ST_COMPLETE;
                                tok_next.total_len = bytes_sum[15:0] + HDR_BYTES;
                                tok_next.socket    = socket_reg;
                            end
                            else
                            begin
                                tok_next.status = ST_HELD;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        ident_reg  <= ident_next;
        proto_reg  <= proto_next;
        socket_reg <= socket_next;
        bytes_reg  <= bytes_next;
        last_reg   <= last_next;
    end

    assign tok_out = tok_reg;

endmodule

@@ hdl/ipfr_chk.sv @@
// Port-level checker for the reassembly table, bound to the top level.
module ipfr_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  status,
    input logic [5:0]  slot,
    input logic [15:0] total_len,
    input logic [6:0]  freed_count
);
    import ipfr_pkg::*;

    // One request in the row at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a request is in the row");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot))
        else $error("stalled result changed");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (slot < 6'(SLOTS)) && (freed_count <= 7'(SLOTS)))
        else $error("slot or freed count out of range");

    a_no_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NO_SOCKET || status == ST_POOL_FIRST ||
                      status == ST_NO_SLOT || status == ST_NO_MATCH ||
                      status == ST_INVAL_DONE || status == ST_CLEARED)
        |-> slot == 6'd0)
        else $error("slot reported without a slot");

    a_len_only_complete: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_COMPLETE |-> total_len == 16'd0)
        else $error("total length on a non-complete result");

endmodule

bind ip_fragment_reassembly_table ipfr_chk u_ipfr_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .slot        (slot),
    .total_len   (total_len),
    .freed_count (freed_count)
);
